@@ hw/rtl/pmsa_pkg.sv @@
// Package for the pin-mux sharing arbiter: defaults, action and status codes, state type.
`default_nettype none
package pmsa_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int SHARE_BITS_DEF  = 32;
  localparam int COUNT_WIDTH_DEF = 8;

  localparam int WORD_BITS = 32;
  localparam int ABSENT_BIT = 31;
  localparam int IDX_BITS = 9;

  localparam logic [1:0] ACT_REQUEST = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_LOAD    = 2'd2;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_INVALID = 2'd1;
  localparam logic [1:0] STS_BUSY    = 2'd2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/pin_mux_share_arbiter.sv @@
// Top level of the pin-mux sharing arbiter: pin table memory, reference counts, share word.
//
// Input channel s_*: s_tuser carries the action (request, release, load), s_tdata carries
// pin_index, load_mask and load_value. Output channel m_*: one result item per input
// item, m_tdata carries status, share_word and reserved_word after that item.
// Each item passes through the states ST_IDLE and ST_EXEC: on acceptance in ST_IDLE the pin
// table memory (a single-port synchronous memory with a registered read) is read; in ST_EXEC
// the block checks and updates the reserved bits, share word and per-bit counts and loads
// the output register. The input is not ready in ST_EXEC, so a new item is taken only after
// the previous one has loaded its result into the output register.
// A new item is accepted while a result still waits in the output register; when the
// receiver stalls, the update cycle holds until that register is taken, and the input
// stops being ready after the next item.
// Reset clears the reserved bits, share word, counts and the per-entry valid bits, so
// every table entry reads as an absent pin until loaded. No clearing pass is needed.
`default_nettype none
module pin_mux_share_arbiter #(
  parameter int TABLE_DEPTH = pmsa_pkg::TABLE_DEPTH_DEF,
  parameter int SHARE_BITS  = pmsa_pkg::SHARE_BITS_DEF,
  parameter int COUNT_WIDTH = pmsa_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // pin_index[5:0], load_mask[37:6], load_value[69:38]
  input  wire logic [1:0]  s_tuser,  // action[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata   // status[1:0], share_word[33:2], reserved_word[65:34]
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SB = SHARE_BITS;
  localparam int CW = COUNT_WIDTH;
  localparam int MemW = 2 * SB + 1;
  localparam logic [pmsa_pkg::IDX_BITS-1:0] DepthLim = pmsa_pkg::IDX_BITS'(TABLE_DEPTH);
  localparam logic [CW-1:0] CntMax = {CW{1'b1}};

  pmsa_pkg::state_t state, state_next;

  logic [MemW-1:0] mem [TABLE_DEPTH];
  logic [MemW-1:0] rd_data;
  logic [TABLE_DEPTH-1:0] valid;
  logic rd_valid;

  logic [1:0] act;
  logic in_range;

  logic [SB-1:0] reserved, share;
  logic [SB-1:0] reserved_next, share_next;
  logic [CW-1:0] cnt [SB];
  logic [CW-1:0] cnt_next [SB];

  logic [1:0] status_next;
  logic accept, exec_go;

  logic [5:0]  in_index;
  logic [31:0] in_mask, in_value;
  logic [pmsa_pkg::IDX_BITS-1:0] idx_ext;
  logic [AW-1:0] addr;
  logic in_ok;

  logic absent;
  logic [SB-1:0] pmask, pval;
  logic [SB-1:0] cnt_zero, cnt_one, zero_vec, first_zero, dec_set, clr_set;
  logic [31:0] share_ext, reserved_ext;

  assign in_index = s_tdata[5:0];
  assign in_mask  = s_tdata[37:6];
  assign in_value = s_tdata[69:38];
  assign idx_ext  = {{(pmsa_pkg::IDX_BITS-6){1'b0}}, in_index};
  assign addr     = idx_ext[AW-1:0];
  assign in_ok    = idx_ext < DepthLim;

  assign accept  = s_tvalid && s_tready;
  assign exec_go = (state == pmsa_pkg::ST_EXEC) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      pmsa_pkg::ST_IDLE: begin
        if (accept) state_next = pmsa_pkg::ST_EXEC;
      end
      pmsa_pkg::ST_EXEC: begin
        if (exec_go) state_next = pmsa_pkg::ST_IDLE;
      end
      default: state_next = pmsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    case (state)
      pmsa_pkg::ST_IDLE: s_tready = 1'b1;
      pmsa_pkg::ST_EXEC: s_tready = 1'b0;
      default:           s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[addr];
      if (in_ok && s_tuser == pmsa_pkg::ACT_LOAD) begin
        mem[addr] <= {in_mask[pmsa_pkg::ABSENT_BIT], in_mask[SB-1:0], in_value[SB-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (accept && in_ok && s_tuser == pmsa_pkg::ACT_LOAD) begin
      valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= s_tuser;
      in_range <= in_ok;
      rd_valid <= valid[addr];
    end
  end

  assign absent = !rd_valid || rd_data[MemW-1];
  assign pmask  = rd_valid ? rd_data[2*SB-1:SB] : '0;
  assign pval   = rd_valid ? rd_data[SB-1:0] : '0;

  always_comb begin
    for (int b = 0; b < SB; b++) begin
      cnt_zero[b] = (cnt[b] == '0);
      cnt_one[b]  = (cnt[b] == CW'(1));
    end
  end

  assign zero_vec   = pmask & cnt_zero;
  assign first_zero = zero_vec & (~zero_vec + SB'(1));
  assign dec_set    = (zero_vec == '0) ? pmask : (pmask & (first_zero - SB'(1)));
  assign clr_set    = dec_set & cnt_one;

  always_comb begin
    reserved_next = reserved;
    share_next    = share;
    status_next   = pmsa_pkg::STS_OK;
    for (int b = 0; b < SB; b++) cnt_next[b] = cnt[b];
    if (!in_range) begin
      status_next = pmsa_pkg::STS_INVALID;
    end else begin
      case (act)
        pmsa_pkg::ACT_REQUEST: begin
          if (absent) begin
            status_next = pmsa_pkg::STS_INVALID;
          end else if (pmask != '0) begin
            if ((pmask & reserved & pval) != (pmask & reserved & share)) begin
              status_next = pmsa_pkg::STS_BUSY;
            end else begin
              reserved_next = reserved | pmask;
              share_next    = (pmask & pval) | (~pmask & share);
              for (int b = 0; b < SB; b++) begin
                if (pmask[b] && cnt[b] != CntMax) cnt_next[b] = cnt[b] + CW'(1);
              end
            end
          end
        end
        pmsa_pkg::ACT_RELEASE: begin
          if (absent) begin
            status_next = pmsa_pkg::STS_INVALID;
          end else if (pmask != '0) begin
            if (zero_vec != '0) status_next = pmsa_pkg::STS_INVALID;
            reserved_next = reserved & ~clr_set;
            share_next    = share & ~clr_set;
            for (int b = 0; b < SB; b++) begin
              if (dec_set[b]) cnt_next[b] = cnt[b] - CW'(1);
            end
          end
        end
        pmsa_pkg::ACT_LOAD: status_next = pmsa_pkg::STS_OK;
        default:            status_next = pmsa_pkg::STS_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
      share    <= '0;
      for (int b = 0; b < SB; b++) cnt[b] <= '0;
    end else if (exec_go) begin
      reserved <= reserved_next;
      share    <= share_next;
      for (int b = 0; b < SB; b++) cnt[b] <= cnt_next[b];
    end
  end

  always_comb begin
    share_ext    = '0;
    reserved_ext = '0;
    share_ext[SB-1:0]    = share_next;
    reserved_ext[SB-1:0] = reserved_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      m_tdata <= {6'd0, reserved_ext, share_ext, status_next};
    end
  end

endmodule
`default_nettype wire
